// ===== rtl/spism_pkg.sv =====
// ----------------------------------------------------------------------------
// spism_pkg: shared types and constants of the spi sensor register master
// command codes, transaction kinds and configuration register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package spism_pkg;

    // command carried with a tick
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_BURST = 2'd3
    } action_t;

    // kind of the running transaction
    typedef enum logic [1:0] {
        KIND_IDLE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_BURST = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] CFG_BURST_START = 2'd0;
    localparam logic [1:0] CFG_BURST_COUNT = 2'd1;

    // reset values of the configuration registers
    localparam logic [6:0] BURST_START_RESET = 7'd59;
    localparam logic [3:0] BURST_COUNT_RESET = 4'd7;

    // result word layout on the master side tdata
    localparam int unsigned TD_CS    = 0;
    localparam int unsigned TD_SCK   = 1;
    localparam int unsigned TD_MOSI  = 2;
    localparam int unsigned TD_BUSY  = 3;
    localparam int unsigned TD_VALID = 4;
    localparam int unsigned TD_VALUE = 5;
    localparam int unsigned TD_INDEX = 21;
    localparam int unsigned TD_WIDTH = 24;

endpackage

`default_nettype wire

// ===== rtl/spi_sensor_register_master_unit.sv =====
// ----------------------------------------------------------------------------
// spi_sensor_register_master_unit: mode 3 spi master for sensor registers
// an accepted tick's pin/result word is registered onto m_ in the next cycle
// throughput: one tick per cycle while m_ is not stalled, set by the single state update per tick
// reset: synchronous active-low; idle, config back to start 59, count 7
// ----------------------------------------------------------------------------
`default_nettype none

module spi_sensor_register_master_unit #(
    parameter int unsigned MAX_BURST_WORDS = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    // tick request: tdata {miso_level, write_value, reg_address}, reg_address from bit 0 up
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [6:0] reg_address, [14:7] write_value, [15] miso_level
    input  wire  [1:0]  s_tuser,   // [1:0] action
    // pin and result word
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] chip_select_n, [1] clock_level, [2] mosi_level, [3] busy_res,
    // [4] result_valid, [20:5] result_value, [23:21] result_index
    output logic [spism_pkg::TD_WIDTH-1:0] m_tdata,
    output logic        m_tlast,   // result_last
    // configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);

    import spism_pkg::*;

    localparam logic [3:0] MAX_WORDS = 4'(MAX_BURST_WORDS);

    // configuration registers
    logic [6:0]  burst_start_reg;
    logic [3:0]  burst_count_reg;

    // transaction state
    kind_t       kind_reg, kind_next;
    logic        half_reg, half_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [4:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  tx_shift_reg, tx_shift_next;
    logic [15:0] rx_shift_reg, rx_shift_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;

    // output stage
    logic                out_valid_reg;
    logic [TD_WIDTH-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    // decoded input fields
    action_t     act;
    logic [6:0]  in_addr;
    logic [7:0]  in_wval;
    logic        in_miso;

    logic        accept;
    logic [3:0]  words;
    logic [4:0]  total;
    logic [4:0]  byte_inc;

    // result fields for this tick
    logic        cs_n, sck, mosi, busy, res_valid, res_last;
    logic [15:0] res_value;
    logic [2:0]  res_index;

    assign act     = action_t'(s_tuser);
    assign in_addr = s_tdata[6:0];
    assign in_wval = s_tdata[14:7];
    assign in_miso = s_tdata[15];

    // take a tick whenever the output word is free or being taken
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // burst length, clamped to the supported range
    always_comb begin
        if (burst_count_reg == 4'd0) begin
            words = 4'd1;
        end else if (burst_count_reg > MAX_WORDS) begin
            words = MAX_WORDS;
        end else begin
            words = burst_count_reg;
        end
        if (kind_reg == KIND_BURST) begin
            total = 5'd1 + {words, 1'b0};
        end else begin
            total = 5'd2;
        end
        byte_inc = byte_cnt_reg + 5'd1;
    end

    // per-tick state update and pin levels
    always_comb begin
        kind_next      = kind_reg;
        half_next      = half_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        tx_shift_next  = tx_shift_reg;
        rx_shift_next  = rx_shift_reg;
        pend_byte_next = pend_byte_reg;
        cs_n      = 1'b1;
        sck       = 1'b1;
        mosi      = 1'b0;
        busy      = 1'b0;
        res_valid = 1'b0;
        res_value = 16'd0;
        res_index = 3'd0;
        res_last  = 1'b0;

        if (kind_reg == KIND_IDLE) begin
            // latch a command, pins still idle
            if (act != ACT_TICK) begin
                kind_next      = kind_t'(act);
                half_next      = 1'b0;
                bit_cnt_next   = 3'd0;
                byte_cnt_next  = 5'd0;
                pend_byte_next = in_wval;
                busy           = 1'b1;
                case (act)
                    ACT_WRITE: tx_shift_next = {1'b0, in_addr};
                    ACT_READ:  tx_shift_next = {1'b1, in_addr};
                    ACT_BURST: tx_shift_next = {1'b1, burst_start_reg};
                    default:   tx_shift_next = tx_shift_reg;
                endcase
            end
        end else if (!half_reg) begin
            // low half: drive mosi
            cs_n      = 1'b0;
            sck       = 1'b0;
            busy      = 1'b1;
            mosi      = tx_shift_reg[7];
            half_next = 1'b1;
        end else begin
            // high half: sample miso
            cs_n          = 1'b0;
            sck           = 1'b1;
            busy          = 1'b1;
            mosi          = tx_shift_reg[7];
            tx_shift_next = {tx_shift_reg[6:0], 1'b0};
            rx_shift_next = {rx_shift_reg[14:0], in_miso};
            half_next     = 1'b0;
            if (bit_cnt_reg == 3'd7) begin
                bit_cnt_next  = 3'd0;
                byte_cnt_next = byte_inc;
                // end of byte: present a read byte or a burst word
                if (kind_reg == KIND_READ && byte_inc == 5'd2) begin
                    res_valid = 1'b1;
                    res_value = {8'd0, rx_shift_next[7:0]};
                    res_last  = 1'b1;
                end else if (kind_reg == KIND_BURST && byte_inc >= 5'd2 &&
                             byte_inc[0]) begin
                    res_valid = 1'b1;
                    res_value = rx_shift_next;
                    res_index = 3'(byte_inc[4:1] - 4'd1);
                    res_last  = (byte_inc == total);
                end
                // next byte to send
                if (byte_inc >= total) begin
                    kind_next     = KIND_IDLE;
                    tx_shift_next = 8'd0;
                end else if (kind_reg == KIND_WRITE && byte_inc == 5'd1) begin
                    tx_shift_next = pend_byte_reg;
                end else begin
                    tx_shift_next = 8'd0;
                end
            end else begin
                bit_cnt_next = bit_cnt_reg + 3'd1;
            end
        end

        out_data_next = {res_index, res_value, res_valid, busy, mosi, sck, cs_n};
        out_last_next = res_last;
    end

    // state, configuration and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_start_reg <= BURST_START_RESET;
            burst_count_reg <= BURST_COUNT_RESET;
            kind_reg        <= KIND_IDLE;
            half_reg        <= 1'b0;
            bit_cnt_reg     <= 3'd0;
            byte_cnt_reg    <= 5'd0;
            tx_shift_reg    <= 8'd0;
            rx_shift_reg    <= 16'd0;
            pend_byte_reg   <= 8'd0;
            out_valid_reg   <= 1'b0;
        end else begin
            // configuration write
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_BURST_START: burst_start_reg <= cfg_data[6:0];
                    CFG_BURST_COUNT: burst_count_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (accept) begin
                kind_reg      <= kind_next;
                half_reg      <= half_next;
                bit_cnt_reg   <= bit_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                tx_shift_reg  <= tx_shift_next;
                rx_shift_reg  <= rx_shift_next;
                pend_byte_reg <= pend_byte_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/spism_checker.sv =====
// ----------------------------------------------------------------------------
// spism_checker: port-level checks of the spi sensor register master
// watches the result word for pin and result consistency
// ----------------------------------------------------------------------------
`default_nettype none

module spism_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [spism_pkg::TD_WIDTH-1:0] m_tdata,
    input wire                         m_tlast
);

    import spism_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a result only on a high half with chip select asserted
    a_result_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[TD_VALID] |->
            !m_tdata[TD_CS] && m_tdata[TD_SCK] && m_tdata[TD_BUSY])
        else $error("result outside a high half of a transaction");

    // last marks only a valid result
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[TD_VALID])
        else $error("last without a result");

    // chip select low implies busy
    a_cs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[TD_CS] |-> m_tdata[TD_BUSY])
        else $error("chip select asserted while not busy");

    // no result means zero value and index
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[TD_VALID] |->
            m_tdata[TD_WIDTH-1:TD_VALUE] == '0)
        else $error("result fields not cleared without a result");

endmodule

bind spi_sensor_register_master_unit spism_checker u_spism_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
